// ----- rtl/psfd_pkg.sv -----
`default_nettype none
package psfd_pkg;

    // Input item: one action event
    typedef struct packed {
        logic [31:0] source_ip;
        logic        privileged;
        logic [31:0] now_ms;
    } t_in_item;

    // Result item: decision for one event
    typedef struct packed {
        logic       allowed;
        logic [2:0] verdict;
    } t_out_item;

    // One source table entry
    typedef struct packed {
        logic [31:0] ip;
        logic [31:0] last_time;
        logic [31:0] elapsed;
        logic [3:0]  count;
        logic        disabled;
    } t_entry;

    // Verdict codes
    localparam logic [2:0] V_ALLOW    = 3'd0;
    localparam logic [2:0] V_DISABLED = 3'd1;
    localparam logic [2:0] V_BANNED   = 3'd2;
    localparam logic [2:0] V_CLOSE    = 3'd3;
    localparam logic [2:0] V_FULL     = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_ACTION_LIMIT = 2'd0;
    localparam logic [1:0] CFG_FAST_WINDOW  = 2'd1;
    localparam logic [1:0] CFG_SLOW_WINDOW  = 2'd2;

    // Configuration reset values
    localparam logic [3:0]  RST_ACTION_LIMIT = 4'd10;
    localparam logic [19:0] RST_FAST_WINDOW  = 20'd10000;
    localparam logic [19:0] RST_SLOW_WINDOW  = 20'd30000;

    // Shared arithmetic unit operations
    typedef enum logic [1:0] {
        ALU_SUB,
        ALU_SATADD,
        ALU_LT
    } t_alu_op;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MISS,
        S_CHECK,
        S_SUM,
        S_FAST,
        S_SLOW
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/psfd_alu.sv -----
`default_nettype none
module psfd_alu (
    input  var psfd_pkg::t_alu_op i_op,
    input  wire logic [31:0]      i_a,
    input  wire logic [31:0]      i_b,
    output logic      [31:0]      o_y,
    output logic                  o_lt
);

    logic [32:0] w_sum;

    // Form the wide sum once for the saturating add
    assign w_sum = {1'b0, i_a} + {1'b0, i_b};

    // Select the operation result
    always_comb begin
        o_y  = '0;
        o_lt = 1'b0;
        unique case (i_op)
            psfd_pkg::ALU_SUB: begin
                o_y = i_a - i_b;
            end
            psfd_pkg::ALU_SATADD: begin
                o_y = w_sum[32] ? '1 : w_sum[31:0];
            end
            psfd_pkg::ALU_LT: begin
                o_lt = (i_a < i_b);
            end
            default: begin
                o_y = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/psfd_table.sv -----
`default_nettype none
module psfd_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rd_en,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0] i_rd_addr,
    output psfd_pkg::t_entry                      o_rd_data,
    input  wire logic                             i_wr_en,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0] i_wr_addr,
    input  var psfd_pkg::t_entry                  i_wr_data
);

    psfd_pkg::t_entry r_mem [TABLE_ENTRIES];
    psfd_pkg::t_entry r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry, hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ----- rtl/per_source_flood_detector.sv -----
// A privileged item gives its result strobe in the cycle after start. Others scan the F
// entries in use, one per cycle on the single read port: a hit goes on to the check (a
// disabled source ends there), the sum, the fast window and, when checked, the slow window;
// a miss goes to the miss state, which takes a free entry or refuses. A new item is taken
// only once the last one is done; busy is high while an item is in work. Reset loads the
// default limits and empties the table through its fill count; the receiver cannot stall.
`default_nettype none
module per_source_flood_detector #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  var psfd_pkg::t_in_item     i_item,
    output logic                       o_done,
    output psfd_pkg::t_out_item        o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [19:0]           i_cfg_wdata
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int FW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [FW-1:0] FULL_COUNT = FW'(TABLE_ENTRIES);

    psfd_pkg::t_state    r_state, n_state;
    psfd_pkg::t_in_item  r_item, n_item;
    logic [FW-1:0]       r_idx, n_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]       r_cmp_idx, n_cmp_idx;
    logic [AW-1:0]       r_hit, n_hit;
    logic [FW-1:0]       r_fill, n_fill;
    logic [31:0]         r_acc, n_acc;
    logic [3:0]          r_cnt, n_cnt;
    logic                r_done, n_done;
    psfd_pkg::t_out_item r_res, n_res;
    logic [3:0]          r_limit;
    logic [19:0]         r_fast;
    logic [19:0]         r_slow;

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    psfd_pkg::t_entry    rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    psfd_pkg::t_entry    wr_data;
    psfd_pkg::t_alu_op   alu_op;
    logic [31:0]         alu_a;
    logic [31:0]         alu_b;
    logic [31:0]         alu_y;
    logic                alu_lt;

    psfd_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .i_clk    (i_clk),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data)
    );

    psfd_alu u_alu (
        .i_op(alu_op),
        .i_a (alu_a),
        .i_b (alu_b),
        .o_y (alu_y),
        .o_lt(alu_lt)
    );

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= psfd_pkg::RST_ACTION_LIMIT;
            r_fast  <= psfd_pkg::RST_FAST_WINDOW;
            r_slow  <= psfd_pkg::RST_SLOW_WINDOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                psfd_pkg::CFG_ACTION_LIMIT: r_limit <= i_cfg_wdata[3:0];
                psfd_pkg::CFG_FAST_WINDOW:  r_fast  <= i_cfg_wdata;
                psfd_pkg::CFG_SLOW_WINDOW:  r_slow  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= psfd_pkg::S_IDLE;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_fill    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            r_fill    <= n_fill;
            r_done    <= n_done;
        end
    end

    // Hold the working payload
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_cmp_idx <= n_cmp_idx;
        r_hit     <= n_hit;
        r_acc     <= n_acc;
        r_cnt     <= n_cnt;
        r_res     <= n_res;
    end

    // Sequence the scan, update and judgment of one item
    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_idx     = r_idx;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_hit     = r_hit;
        n_fill    = r_fill;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_done    = 1'b0;
        n_res     = r_res;
        rd_en     = 1'b0;
        rd_addr   = r_idx[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_hit;
        wr_data   = '{ip: r_item.source_ip, last_time: r_item.now_ms,
                      elapsed: '0, count: '0, disabled: 1'b0};
        alu_op    = psfd_pkg::ALU_SUB;
        alu_a     = r_item.now_ms;
        alu_b     = rd_data.last_time;

        unique case (r_state)
            psfd_pkg::S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    if (i_item.privileged) begin
                        n_done = 1'b1;
                        n_res  = '{allowed: 1'b1, verdict: psfd_pkg::V_ALLOW};
                    end else begin
                        n_idx   = '0;
                        n_state = psfd_pkg::S_SCAN;
                    end
                end
            end
            psfd_pkg::S_SCAN: begin
                // One compare per cycle against the entry read the cycle before
                if (r_cmp_vld && (rd_data.ip == r_item.source_ip)) begin
                    n_hit   = r_cmp_idx;
                    n_state = psfd_pkg::S_CHECK;
                end else if (r_idx < r_fill) begin
                    rd_en     = 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[AW-1:0];
                    n_idx     = r_idx + 1'b1;
                end else if (!r_cmp_vld) begin
                    n_state = psfd_pkg::S_MISS;
                end
            end
            psfd_pkg::S_MISS: begin
                // Take the next free entry or refuse
                n_done  = 1'b1;
                n_state = psfd_pkg::S_IDLE;
                if (r_fill == FULL_COUNT) begin
                    n_res = '{allowed: 1'b0, verdict: psfd_pkg::V_FULL};
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_fill[AW-1:0];
                    n_fill  = r_fill + 1'b1;
                    n_res   = '{allowed: 1'b1, verdict: psfd_pkg::V_ALLOW};
                end
            end
            psfd_pkg::S_CHECK: begin
                // Drop disabled sources, else take the time step
                if (rd_data.disabled) begin
                    n_done  = 1'b1;
                    n_res   = '{allowed: 1'b0, verdict: psfd_pkg::V_DISABLED};
                    n_state = psfd_pkg::S_IDLE;
                end else begin
                    alu_op  = psfd_pkg::ALU_SUB;
                    alu_a   = r_item.now_ms;
                    alu_b   = rd_data.last_time;
                    n_acc   = alu_y;
                    n_state = psfd_pkg::S_SUM;
                end
            end
            psfd_pkg::S_SUM: begin
                // Accumulate with saturation and count the action
                alu_op  = psfd_pkg::ALU_SATADD;
                alu_a   = rd_data.elapsed;
                alu_b   = r_acc;
                n_acc   = alu_y;
                n_cnt   = rd_data.count + 4'd1;
                n_state = psfd_pkg::S_FAST;
            end
            psfd_pkg::S_FAST: begin
                alu_op = psfd_pkg::ALU_LT;
                alu_a  = r_acc;
                alu_b  = {12'd0, r_fast};
                if (r_cnt != r_limit) begin
                    wr_en   = 1'b1;
                    wr_data = '{ip: r_item.source_ip, last_time: r_item.now_ms,
                                elapsed: r_acc, count: r_cnt, disabled: 1'b0};
                    n_done  = 1'b1;
                    n_res   = '{allowed: 1'b1, verdict: psfd_pkg::V_ALLOW};
                    n_state = psfd_pkg::S_IDLE;
                end else if (alu_lt) begin
                    wr_en   = 1'b1;
                    wr_data = '{ip: r_item.source_ip, last_time: r_item.now_ms,
                                elapsed: '0, count: '0, disabled: 1'b1};
                    n_done  = 1'b1;
                    n_res   = '{allowed: 1'b0, verdict: psfd_pkg::V_BANNED};
                    n_state = psfd_pkg::S_IDLE;
                end else begin
                    n_state = psfd_pkg::S_SLOW;
                end
            end
            psfd_pkg::S_SLOW: begin
                alu_op  = psfd_pkg::ALU_LT;
                alu_a   = r_acc;
                alu_b   = {12'd0, r_slow};
                wr_en   = 1'b1;
                n_done  = 1'b1;
                n_state = psfd_pkg::S_IDLE;
                if (alu_lt) begin
                    n_res = '{allowed: 1'b0, verdict: psfd_pkg::V_CLOSE};
                end else begin
                    n_res = '{allowed: 1'b1, verdict: psfd_pkg::V_ALLOW};
                end
            end
            default: begin
                n_state = psfd_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != psfd_pkg::S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // A result never shows while an item is still in work
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // The fill count never passes the table size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_COUNT)
        else $error("fill count beyond table size");

    // The fill count grows by one at a time
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |-> (r_fill == $past(r_fill) + 1'b1))
        else $error("fill count jumped");

    // A privileged item is answered in the next cycle
    a_priv_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.privileged) |=> (o_done && !busy))
        else $error("privileged item not answered at once");

    // A table write happens only on the cycle that finishes an item
    a_wr_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> n_done)
        else $error("table write outside item completion");

endmodule
`default_nettype wire

// ----- tb/sv/psfd_checker.sv -----
`timescale 1ns / 1ps
module psfd_checker #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  var psfd_pkg::t_in_item   i_item,
    input  wire logic                o_done,
    input  var psfd_pkg::t_out_item  o_result,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [19:0]         i_cfg_wdata,
    output int                       o_fail_count,
    output int                       o_pending
);

    // Shadow copy of the source table and the limits
    logic                src_valid [TABLE_ENTRIES];
    psfd_pkg::t_entry    src_table [TABLE_ENTRIES];
    logic [3:0]          action_limit;
    logic [19:0]         fast_window;
    logic [19:0]         slow_window;

    // Verdicts still owed by the block, oldest first
    psfd_pkg::t_out_item verdict_q [$];
    psfd_pkg::t_out_item want;
    int                  mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Decide one action event and update the shadow table
    function automatic psfd_pkg::t_out_item judge_action(input psfd_pkg::t_in_item ev);
        int                  hit;
        int                  free_slot;
        logic [31:0]         delta;
        logic [32:0]         sum;
        logic [31:0]         total;
        psfd_pkg::t_out_item res;
        hit = -1;
        free_slot = -1;
        res.allowed = 1'b1;
        res.verdict = psfd_pkg::V_ALLOW;
        if (ev.privileged)
            return res;

        // Find the lowest matching entry and the lowest free one
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (src_valid[i]) begin
                if (hit < 0 && src_table[i].ip == ev.source_ip)
                    hit = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end

        // Unknown source: take a free entry, or refuse when the table is full
        if (hit < 0) begin
            if (free_slot < 0) begin
                res.allowed = 1'b0;
                res.verdict = psfd_pkg::V_FULL;
                return res;
            end
            src_valid[free_slot]           = 1'b1;
            src_table[free_slot].ip        = ev.source_ip;
            src_table[free_slot].last_time = ev.now_ms;
            src_table[free_slot].elapsed   = '0;
            src_table[free_slot].count     = '0;
            src_table[free_slot].disabled  = 1'b0;
            return res;
        end

        if (src_table[hit].disabled) begin
            res.allowed = 1'b0;
            res.verdict = psfd_pkg::V_DISABLED;
            return res;
        end

        // Accumulate elapsed time modulo 2^32, saturating the sum
        delta = ev.now_ms - src_table[hit].last_time;
        sum   = {1'b0, src_table[hit].elapsed} + {1'b0, delta};
        total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        src_table[hit].elapsed   = total;
        src_table[hit].last_time = ev.now_ms;
        src_table[hit].count     = src_table[hit].count + 4'd1;

        // Judge at the limit, then clear count and sum
        if (src_table[hit].count == action_limit) begin
            src_table[hit].count   = '0;
            src_table[hit].elapsed = '0;
            if (total < {12'd0, fast_window}) begin
                src_table[hit].disabled = 1'b1;
                res.allowed = 1'b0;
                res.verdict = psfd_pkg::V_BANNED;
            end else if (total < {12'd0, slow_window}) begin
                res.allowed = 1'b0;
                res.verdict = psfd_pkg::V_CLOSE;
            end
        end
        return res;
    endfunction

    // Track register writes, predict accepted items, compare strobed results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                src_valid[i] = 1'b0;
            action_limit = psfd_pkg::RST_ACTION_LIMIT;
            fast_window  = psfd_pkg::RST_FAST_WINDOW;
            slow_window  = psfd_pkg::RST_SLOW_WINDOW;
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    psfd_pkg::CFG_ACTION_LIMIT: action_limit = i_cfg_wdata[3:0];
                    psfd_pkg::CFG_FAST_WINDOW:  fast_window  = i_cfg_wdata;
                    psfd_pkg::CFG_SLOW_WINDOW:  slow_window  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (start && !busy)
                verdict_q.push_back(judge_action(i_item));
            if (o_done) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("result allowed=%0d verdict=%0d with no item pending",
                                              o_result.allowed, o_result.verdict));
                end else begin
                    want = verdict_q.pop_front();
                    if (o_result.allowed !== want.allowed)
                        report_mismatch($sformatf("allowed: got %0d, want %0d",
                                                  o_result.allowed, want.allowed));
                    if (o_result.verdict !== want.verdict)
                        report_mismatch($sformatf("verdict: got %0d, want %0d",
                                                  o_result.verdict, want.verdict));
                end
            end
        end
        o_pending <= verdict_q.size();
    end

endmodule

// ----- tb/sv/tb_per_source_flood_detector.sv -----
`timescale 1ns / 1ps
module tb_per_source_flood_detector;

    localparam int ENTRIES         = 64;
    localparam int POOL_SIZE       = 56;
    localparam int HOT_SIZE        = 16;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int MAX_IDLE        = 40;
    localparam int SETTLE_CYCLES   = ENTRIES + 16;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    psfd_pkg::t_in_item  i_item      = '0;
    logic                i_cfg_we    = 1'b0;
    logic [1:0]          i_cfg_idx   = psfd_pkg::CFG_ACTION_LIMIT;
    logic [19:0]         i_cfg_wdata = '0;
    logic                busy;
    logic                o_done;
    psfd_pkg::t_out_item o_result;

    int          fail_count;
    int          pending_count;
    int          idle_pct     = 37;
    int          item_count   = 0;
    int          stall_cycles = 0;
    int          step_unit    = 1000;
    logic [31:0] pool_ip   [POOL_SIZE];
    logic [31:0] pool_time [POOL_SIZE];

    per_source_flood_detector #(
        .TABLE_ENTRIES(ENTRIES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    psfd_checker #(
        .TABLE_ENTRIES(ENTRIES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .o_done       (o_done),
        .o_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic psfd_pkg::t_in_item mk_action(input logic [31:0] ip, input logic priv,
                                                     input logic [31:0] now);
        psfd_pkg::t_in_item ev;
        ev.source_ip  = ip;
        ev.privileged = priv;
        ev.now_ms     = now;
        return ev;
    endfunction

    // Pick a time step scaled to the current windows, sometimes huge
    function automatic logic [31:0] pick_step_ms(input int unit);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            return $urandom_range(0, unit / 2);
        else if (pick < 75)
            return $urandom_range(unit / 2, unit * 2);
        else if (pick < 95)
            return $urandom_range(unit * 2, unit * 8);
        return $urandom;
    endfunction

    // Present one item after a random idle gap; return at the edge that takes it
    task automatic send_action(input psfd_pkg::t_in_item ev);
        int gap;
        gap = 0;
        while (gap < MAX_IDLE && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= ev;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        item_count++;
    endtask

    // Drop start and wait until every result is back
    task automatic drain;
        start <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0 || busy);
        @(posedge i_clk);
    endtask

    // Write all three limits back to back and rescale the time steps
    task automatic load_limits(input logic [3:0] lim, input logic [19:0] fast,
                               input logic [19:0] slow);
        int span;
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= psfd_pkg::CFG_ACTION_LIMIT;
        i_cfg_wdata <= {16'd0, lim};
        @(posedge i_clk);
        i_cfg_idx   <= psfd_pkg::CFG_FAST_WINDOW;
        i_cfg_wdata <= fast;
        @(posedge i_clk);
        i_cfg_idx   <= psfd_pkg::CFG_SLOW_WINDOW;
        i_cfg_wdata <= slow;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        span = (fast > slow) ? fast : slow;
        if (span < 1000)
            span = 1000;
        step_unit = span / ((lim == 4'd0) ? 16 : lim);
    endtask

    // Mostly known sources on their own clocks; some fresh and privileged noise
    task automatic send_random_action(input int phase);
        psfd_pkg::t_in_item ev;
        int                 k;
        int                 pick;
        pick = $urandom_range(0, 99);
        ev.privileged = (pick < 8);
        if (pick >= 8 && pick < 13) begin
            ev.source_ip = $urandom;
            ev.now_ms    = $urandom;
        end else begin
            if ($urandom_range(0, 3) != 0)
                k = (phase * 8 + $urandom_range(0, HOT_SIZE - 1)) % POOL_SIZE;
            else
                k = $urandom_range(0, POOL_SIZE - 1);
            ev.source_ip = pool_ip[k];
            if ($urandom_range(0, 49) == 0) begin
                ev.now_ms = $urandom;
            end else begin
                pool_time[k] = pool_time[k] + pick_step_ms(step_unit);
                ev.now_ms    = pool_time[k];
            end
        end
        send_action(ev);
    endtask

    initial begin
        logic [3:0]  ph_limit [NUM_PHASES];
        logic [19:0] ph_fast  [NUM_PHASES];
        logic [19:0] ph_slow  [NUM_PHASES];
        ph_limit = '{4'd10, 4'd15, 4'd1, 4'd0, 4'd4, 4'd7, 4'd12};
        ph_fast  = '{20'd10000, 20'd200000, 20'd0, 20'd5000, 20'd20000, 20'd1000000, 20'd0};
        ph_slow  = '{20'd30000, 20'd1000000, 20'd0, 20'd40000, 20'd1000000, 20'd0,
                     20'd1000000};
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_ip[k]   = $urandom;
            pool_time[k] = $urandom;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: short limit so each judgment comes quickly
        load_limits(4'd3, 20'd10000, 20'd30000);
        send_action(mk_action(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
        // new source, then a fast burst that bans it, then refused for good
        send_action(mk_action(32'h0000_0000, 1'b0, 32'd0));
        send_action(mk_action(32'h0000_0000, 1'b0, 32'd1000));
        send_action(mk_action(32'h0000_0000, 1'b0, 32'd2000));
        send_action(mk_action(32'h0000_0000, 1'b0, 32'd3000));
        send_action(mk_action(32'h0000_0000, 1'b0, 32'd50000));
        // privileged bypasses a disabled entry
        send_action(mk_action(32'h0000_0000, 1'b1, 32'd60000));
        // slow burst closes the connection
        send_action(mk_action(32'hFFFF_FFFF, 1'b0, 32'd0));
        send_action(mk_action(32'hFFFF_FFFF, 1'b0, 32'd5000));
        send_action(mk_action(32'hFFFF_FFFF, 1'b0, 32'd15000));
        send_action(mk_action(32'hFFFF_FFFF, 1'b0, 32'd25000));
        // timer wrap, time going back, elapsed saturation
        send_action(mk_action(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFF0));
        send_action(mk_action(32'hFFFF_FFFF, 1'b0, 32'h0000_0010));
        send_action(mk_action(32'hFFFF_FFFF, 1'b0, 32'h0000_0005));
        // elapsed exactly at the fast window: close, not ban
        send_action(mk_action(32'h8000_0000, 1'b0, 32'd100));
        send_action(mk_action(32'h8000_0000, 1'b0, 32'd4100));
        send_action(mk_action(32'h8000_0000, 1'b0, 32'd7100));
        send_action(mk_action(32'h8000_0000, 1'b0, 32'd10100));
        // elapsed exactly at the slow window: allow
        send_action(mk_action(32'h1234_5678, 1'b0, 32'd0));
        send_action(mk_action(32'h1234_5678, 1'b0, 32'd10000));
        send_action(mk_action(32'h1234_5678, 1'b0, 32'd20000));
        send_action(mk_action(32'h1234_5678, 1'b0, 32'd30000));
        drain();

        // Random phases, each under its own limits
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            load_limits(ph_limit[ph], ph_fast[ph], ph_slow[ph]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (item_count < 455)
                    idle_pct = 37;
                else if (item_count < 890)
                    idle_pct = 78;
                else
                    idle_pct = 0;
                send_random_action(ph);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/psfd_pkg.sv
rtl/psfd_alu.sv
rtl/psfd_table.sv
rtl/per_source_flood_detector.sv
tb/sv/psfd_checker.sv
tb/sv/tb_per_source_flood_detector.sv
